FILE: rtl/pta_pkg.sv
`default_nettype none

package pta_pkg;

  localparam int ELAPSED_W = 26;
  localparam int MAG_W = 4;
  localparam int DEBOUNCE_W = 16;
  localparam int RPM_W = 18;
  localparam int DIV_W = 30;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 26;
  localparam int Q_DEPTH = 4;
  localparam int AVG_DEPTH_DEF = 20;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 26'h3FF_FFFF;
  localparam logic [RPM_W-1:0] RPM_MAX = 18'h3_FFFF;
  localparam logic [DIV_W-1:0] RPM_NUMERATOR = 30'd960000000;

  localparam logic [CFG_IDX_W-1:0] REG_MAGNETS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd3;

  localparam logic [MAG_W-1:0] MAGNETS_RST = 4'd1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd5000;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = 26'd1000000;
  localparam logic [RPM_W-1:0] THRESHOLD_RST = 18'd36800;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_TIMEOUT,
    KIND_EDGE
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [ELAPSED_W-1:0] interval;
  } qent_t;

  typedef struct packed {
    logic [MAG_W-1:0]      magnets;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [ELAPSED_W-1:0]  timeout;
    logic [RPM_W-1:0]      threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPM_START,
    ST_RPM_WAIT,
    ST_AVG_START,
    ST_AVG_WAIT
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/pta_tick_if.sv
`default_nettype none

interface pta_tick_if;
  logic valid;
  logic ready;
  logic hall_fall;

  modport source (output valid, output hall_fall, input ready);
  modport sink (input valid, input hall_fall, output ready);
endinterface

`default_nettype wire

FILE: rtl/pta_result_if.sv
`default_nettype none

interface pta_result_if;
  logic                         valid;
  logic                         ready;
  logic [pta_pkg::RPM_W-1:0]    rpm_avg;
  logic                         charge_on;
  logic                         fresh;

  modport source (output valid, output rpm_avg, output charge_on, output fresh, input ready);
  modport sink (input valid, input rpm_avg, input charge_on, input fresh, output ready);
endinterface

`default_nettype wire

FILE: rtl/pta_cfg_if.sv
`default_nettype none

interface pta_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pta_pkg::CFG_IDX_W-1:0]    index;
  logic [pta_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pulse_tachometer_avg.sv
// A tick without an accepted edge passes through the request queue and then the output register.
// A tick with an accepted edge makes one pass through the restoring divider for the rpm,
// then a registered reciprocal multiply for the ring average.
// Ticks are taken one per cycle while the four-entry request queue has room.
// Synchronous active-high reset restores the register defaults and clears the tick
// counter, the ring (through per-entry valid bits), the sum and the shown rpm.
`default_nettype none

module pulse_tachometer_avg #(
  parameter int AVG_DEPTH = pta_pkg::AVG_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  pta_tick_if.sink       tick,
  pta_result_if.source   result,
  pta_cfg_if.sink        cfg
);

  pta_pkg::cfg_t  cfg_regs;
  pta_pkg::qent_t push_data;
  pta_pkg::qent_t pop_data;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.magnets <= pta_pkg::MAGNETS_RST;
      cfg_regs.debounce <= pta_pkg::DEBOUNCE_RST;
      cfg_regs.timeout <= pta_pkg::TIMEOUT_RST;
      cfg_regs.threshold <= pta_pkg::THRESHOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pta_pkg::REG_MAGNETS: cfg_regs.magnets <= cfg.data[pta_pkg::MAG_W-1:0];
        pta_pkg::REG_DEBOUNCE: cfg_regs.debounce <= cfg.data[pta_pkg::DEBOUNCE_W-1:0];
        pta_pkg::REG_TIMEOUT: cfg_regs.timeout <= cfg.data[pta_pkg::ELAPSED_W-1:0];
        pta_pkg::REG_THRESHOLD: cfg_regs.threshold <= cfg.data[pta_pkg::RPM_W-1:0];
        default: ;
      endcase
    end
  end

  pta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cfg_regs  (cfg_regs),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  pta_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: rtl/pta_queue.sv
`default_nettype none

module pta_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  pta_pkg::qent_t      push_data,
  output logic                full,
  input  wire logic           pop,
  output pta_pkg::qent_t      pop_data,
  output logic                empty
);

  localparam int PTR_W = $clog2(pta_pkg::Q_DEPTH);

  pta_pkg::qent_t   entries [pta_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full = (count == (PTR_W+1)'(pta_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("request popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/pta_front.sv
`default_nettype none

module pta_front (
  input  wire logic        clk,
  input  wire logic        rst,
  pta_tick_if.sink         tick,
  input  pta_pkg::cfg_t    cfg_regs,
  input  wire logic        q_full,
  output logic             push,
  output pta_pkg::qent_t   push_data
);

  logic [pta_pkg::ELAPSED_W-1:0] elapsed;
  logic [pta_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic                          edge_ok;

  assign tick.ready = !q_full;
  assign push = tick.valid && tick.ready;

  always_comb begin
    elapsed_inc = (elapsed == pta_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
    edge_ok = tick.hall_fall &&
              (elapsed_inc > {{(pta_pkg::ELAPSED_W-pta_pkg::DEBOUNCE_W){1'b0}},
                              cfg_regs.debounce});
    push_data.interval = elapsed_inc;
    if (edge_ok) begin
      push_data.kind = pta_pkg::KIND_EDGE;
    end else if (elapsed_inc > cfg_regs.timeout) begin
      push_data.kind = pta_pkg::KIND_TIMEOUT;
    end else begin
      push_data.kind = pta_pkg::KIND_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (push) begin
      elapsed <= edge_ok ? '0 : elapsed_inc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pta_div.sv
`default_nettype none

module pta_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pta_pkg::DIV_W-1:0]  dividend,
  input  wire logic [pta_pkg::DIV_W-1:0]  divisor,
  output logic                            busy,
  output logic [pta_pkg::DIV_W-1:0]       quot
);

  localparam int DW = pta_pkg::DIV_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW:0]      rem;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic [DW-1:0]    quo;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;

  assign busy = running;
  assign quot = quo;
  assign rem_sh = {rem[DW-1:0], quo[DW-1]};
  assign diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt <= CNT_W'(DW);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= diff[DW] ? rem_sh : diff;
      quo <= {quo[DW-2:0], ~diff[DW]};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

FILE: rtl/pta_back.sv
`default_nettype none

module pta_back #(
  parameter int AVG_DEPTH = pta_pkg::AVG_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  pta_pkg::cfg_t    cfg_regs,
  input  wire logic        q_empty,
  input  pta_pkg::qent_t   q_data,
  output logic             q_pop,
  pta_result_if.source     result
);

  localparam int POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W = pta_pkg::RPM_W + $clog2(AVG_DEPTH);
  localparam int DW = pta_pkg::DIV_W;
  localparam int RW = pta_pkg::RPM_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);

  // The average is a multiply by the rounded-up reciprocal of the depth, exact for every sum.
  localparam int RECIP_K = SUM_W + $clog2(AVG_DEPTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_M_L =
      ((64'd1 << RECIP_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_M_L);

  pta_pkg::back_state_t state;
  pta_pkg::back_state_t state_next;

  logic [RW-1:0]        ring_mem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] ring_vld;
  logic [POS_W-1:0]     ring_pos;
  logic [RW-1:0]        ring_rd;
  logic                 ring_rd_vld;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_next;
  logic [RW-1:0]        shown;
  logic [RW-1:0]        shown_next;
  logic [DW-1:0]        den;
  logic [DW-1:0]        den_prod;
  logic [pta_pkg::MAG_W-1:0] mag_eff;
  logic [RW-1:0]        rpm_sat;
  logic [RW-1:0]        old_rpm;
  logic [PROD_W-1:0]    avg_full;
  logic [RW-1:0]        avg_q;

  logic                 out_valid;
  logic                 out_free;
  logic [RW-1:0]        out_rpm;
  logic                 out_charge;
  logic                 out_fresh;

  logic                 div_start;
  logic                 div_busy;
  logic [DW-1:0]        div_a;
  logic [DW-1:0]        div_b;
  logic [DW-1:0]        div_quot;
  logic                 load_mul;
  logic                 load_avg;
  logic                 ring_we;
  logic                 load_out;

  pta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  assign result.valid = out_valid;
  assign result.rpm_avg = out_rpm;
  assign result.charge_on = out_charge;
  assign result.fresh = out_fresh;
  assign out_free = !out_valid || result.ready;

  assign mag_eff = (cfg_regs.magnets == '0) ? pta_pkg::MAG_W'(1) : cfg_regs.magnets;
  assign den_prod = {{(DW-pta_pkg::ELAPSED_W){1'b0}}, q_data.interval} *
                    {{(DW-pta_pkg::MAG_W){1'b0}}, mag_eff};
  assign rpm_sat = (|div_quot[DW-1:RW]) ? pta_pkg::RPM_MAX : div_quot[RW-1:0];
  assign old_rpm = ring_rd_vld ? ring_rd : '0;
  assign sum_next = sum - {{(SUM_W-RW){1'b0}}, old_rpm} + {{(SUM_W-RW){1'b0}}, rpm_sat};
  assign avg_full = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_M};

  always_comb begin
    state_next = state;
    unique case (state)
      pta_pkg::ST_IDLE: begin
        if (!q_empty && (q_data.kind == pta_pkg::KIND_EDGE)) begin
          state_next = pta_pkg::ST_RPM_START;
        end
      end
      pta_pkg::ST_RPM_START: state_next = pta_pkg::ST_RPM_WAIT;
      pta_pkg::ST_RPM_WAIT: begin
        if (!div_busy) begin
          state_next = pta_pkg::ST_AVG_START;
        end
      end
      pta_pkg::ST_AVG_START: state_next = pta_pkg::ST_AVG_WAIT;
      pta_pkg::ST_AVG_WAIT: begin
        if (out_free) begin
          state_next = pta_pkg::ST_IDLE;
        end
      end
      default: state_next = pta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load_mul = 1'b0;
    load_avg = 1'b0;
    div_start = 1'b0;
    div_a = pta_pkg::RPM_NUMERATOR;
    div_b = den;
    ring_we = 1'b0;
    load_out = 1'b0;
    shown_next = shown;
    unique case (state)
      pta_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == pta_pkg::KIND_EDGE) begin
            q_pop = 1'b1;
            load_mul = 1'b1;
          end else if (out_free) begin
            q_pop = 1'b1;
            load_out = 1'b1;
            if (q_data.kind == pta_pkg::KIND_TIMEOUT) begin
              shown_next = '0;
            end
          end
        end
      end
      pta_pkg::ST_RPM_START: div_start = 1'b1;
      pta_pkg::ST_RPM_WAIT: ring_we = !div_busy;
      pta_pkg::ST_AVG_START: load_avg = 1'b1;
      pta_pkg::ST_AVG_WAIT: begin
        shown_next = avg_q;
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pta_pkg::ST_IDLE;
      ring_vld <= '0;
      ring_pos <= '0;
      sum <= '0;
      shown <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ring_we) begin
        ring_vld[ring_pos] <= 1'b1;
        ring_pos <= (ring_pos == POS_LAST) ? '0 : ring_pos + 1'b1;
        sum <= sum_next;
      end
      if (load_out) begin
        shown <= shown_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ring_rd <= ring_mem[ring_pos];
    ring_rd_vld <= ring_vld[ring_pos];
    if (ring_we) begin
      ring_mem[ring_pos] <= rpm_sat;
    end
    if (load_mul) begin
      den <= den_prod;
    end
    if (load_avg) begin
      avg_q <= avg_full[RECIP_K +: RW];
    end
    if (load_out) begin
      out_rpm <= shown_next;
      out_charge <= (shown_next > cfg_regs.threshold);
      out_fresh <= (state == pta_pkg::ST_AVG_WAIT);
    end
  end

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_out_matches_shown: assert property (@(posedge clk) disable iff (rst)
      result.valid |-> (result.rpm_avg == shown))
    else $error("presented rpm differs from shown rpm");

endmodule

`default_nettype wire
